>>> src/plnorm_pkg.sv
// Shared types and constants for the piecewise linear L2 norm core.
package plnorm_pkg;

  localparam int unsigned ACC_W  = 64;
  localparam int unsigned TERM_W = 51;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned MUL_W  = 18;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned NORM_W = 32;
  localparam int unsigned LO_W   = 17;

  localparam int unsigned CNT_W     = 6;
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(NORM_W - 1);

  typedef struct packed {
    logic               start;
    logic [ACC_W-2:0]   value;
  } plnorm_root_req_t;

  typedef struct packed {
    logic               done;
    logic [NORM_W-1:0]  root;
  } plnorm_root_rsp_t;

endpackage

>>> src/plnorm_root.sv
// Floor of the square root of value/3, one bit per cycle.
module plnorm_root (
  input  logic                         clk,
  input  logic                         rst,
  input  plnorm_pkg::plnorm_root_req_t req,
  output plnorm_pkg::plnorm_root_rsp_t rsp
);
  import plnorm_pkg::*;

  typedef enum logic {R_IDLE, R_RUN} rstate_t;

  rstate_t            state;
  logic [CNT_W-1:0]   cnt;
  logic [ACC_W-2:0]   rem;
  logic [ACC_W-1:0]   res;
  logic [ACC_W-1:0]   probe;
  logic               done;

  logic [ACC_W-1:0]   trial;
  logic [ACC_W+1:0]   trial3;
  logic               take;

  // largest r with 3*r*r <= value, built from the top bit down
  always_comb begin
    trial  = res | probe;
    trial3 = {2'b00, trial} + {1'b0, trial, 1'b0};
    take   = ({3'b000, rem} >= trial3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (req.start) begin
            rem   <= req.value;
            res   <= '0;
            probe <= {2'b01, {(ACC_W-2){1'b0}}};
            cnt   <= '0;
            state <= R_RUN;
          end
        end
        R_RUN: begin
          if (take) begin
            rem <= (ACC_W-1)'({3'b000, rem} - trial3);
            res <= (res >> 1) + probe;
          end else begin
            res <= res >> 1;
          end
          probe <= probe >> 2;
          if (cnt == SQRT_LAST) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[NORM_W-1:0];

endmodule

>>> src/piecewise_linear_l2_norm_core.sv
// Top level: L2 norm of a piecewise linear curve given point by point.
//
// Input channel: in_valid / in_stall carry one curve point (x_coord, y_value
// in signed Q8.8, is_last on the final point). The block stalls its input
// while it works on a point, so one point is in flight at a time.
// Each point after the first closes a segment; one shared 18x18 multiplier
// forms the three y products and the two halves of the dx product in turn.
// Such a point passes through 7 sequencer steps, the accumulate and the
// state update before the next one can be taken. The first point of a
// curve skips straight to the state update.
// On a point marked last with a non-negative sum, a bit-serial square root
// of sum/3 runs before the result is loaded into the output register; for a
// negative sum the root is skipped and norm is zero. The next point is taken
// in the cycle after the result is loaded.
// Output channel: out_valid / out_stall carry norm (unsigned Q20.12),
// negative_total and saturated. The result sits in an output register and
// holds while out_stall is high; points of the next curve are taken and
// worked on meanwhile, and only a further result waits for that register.
// Reset clears the curve state and drops any pending result.
module piecewise_linear_l2_norm_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] x_coord,
  input  logic [15:0] y_value,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] norm,
  output logic        negative_total,
  output logic        saturated
);
  import plnorm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_ACC, S_POST, S_ROOT, S_FIN} state_t;
  typedef enum logic [2:0] {
    ST_PP, ST_PY, ST_YY, ST_SUM, ST_DLO, ST_DHI, ST_TERM
  } step_t;

  state_t               state;
  step_t                step;
  logic [15:0]          cur_x;
  logic [15:0]          cur_y;
  logic                 cur_last;
  logic [15:0]          prev_x;
  logic [15:0]          prev_y;
  logic                 have_prev;
  logic [ACC_W-1:0]     acc;
  logic                 sat_seen;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     ssum;
  logic [TERM_W-1:0]    term;
  logic [NORM_W-1:0]    fin_norm;
  logic                 fin_neg;
  logic                 fin_sat;

  logic [16:0]          dx;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [ACC_W:0]       acc_sum;
  logic                 acc_ovf;

  plnorm_root_req_t     root_req;
  plnorm_root_rsp_t     root_rsp;

  always_comb begin
    dx = {cur_x[15], cur_x} - {prev_x[15], prev_x};
    unique case (step)
      ST_PP: begin
        mul_a = {{2{prev_y[15]}}, prev_y};
        mul_b = {{2{prev_y[15]}}, prev_y};
      end
      ST_PY: begin
        mul_a = {{2{prev_y[15]}}, prev_y};
        mul_b = {{2{cur_y[15]}}, cur_y};
      end
      ST_YY: begin
        mul_a = {{2{cur_y[15]}}, cur_y};
        mul_b = {{2{cur_y[15]}}, cur_y};
      end
      ST_DLO: begin
        mul_a = {dx[16], dx};
        mul_b = {1'b0, ssum[LO_W-1:0]};
      end
      ST_DHI: begin
        mul_a = {dx[16], dx};
        mul_b = {1'b0, ssum[SUM_W-1:LO_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p   = PROD_W'($signed(mul_a) * $signed(mul_b));
    acc_sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};
    acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
  end

  assign in_stall       = rst || (state != S_IDLE);
  assign root_req.start = (state == S_POST) && cur_last && !acc[ACC_W-1];
  assign root_req.value = acc[ACC_W-2:0];

  plnorm_root u_root (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_PP;
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
      acc       <= '0;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_x    <= x_coord;
            cur_y    <= y_value;
            cur_last <= is_last;
            step     <= ST_PP;
            state    <= have_prev ? S_CALC : S_POST;
          end
        end
        S_CALC: begin
          unique case (step)
            ST_PP: begin
              prod <= mul_p;
              step <= ST_PY;
            end
            ST_PY: begin
              ssum <= prod[SUM_W-1:0];
              prod <= mul_p;
              step <= ST_YY;
            end
            ST_YY: begin
              ssum <= ssum + prod[SUM_W-1:0];
              prod <= mul_p;
              step <= ST_SUM;
            end
            ST_SUM: begin
              ssum <= ssum + prod[SUM_W-1:0];
              step <= ST_DLO;
            end
            ST_DLO: begin
              prod <= mul_p;
              step <= ST_DHI;
            end
            ST_DHI: begin
              term <= {{(TERM_W-PROD_W){prod[PROD_W-1]}}, prod};
              prod <= mul_p;
              step <= ST_TERM;
            end
            ST_TERM: begin
              term  <= term + {prod[TERM_W-LO_W-1:0], {LO_W{1'b0}}};
              step  <= ST_PP;
              state <= S_ACC;
            end
            default: step <= ST_PP;
          endcase
        end
        S_ACC: begin
          if (acc_ovf) begin
            acc      <= {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}};
            sat_seen <= 1'b1;
          end else begin
            acc <= acc_sum[ACC_W-1:0];
          end
          state <= S_POST;
        end
        S_POST: begin
          if (cur_last) begin
            fin_sat   <= sat_seen;
            fin_neg   <= acc[ACC_W-1];
            fin_norm  <= '0;
            prev_x    <= '0;
            prev_y    <= '0;
            have_prev <= 1'b0;
            acc       <= '0;
            sat_seen  <= 1'b0;
            state     <= acc[ACC_W-1] ? S_FIN : S_ROOT;
          end else begin
            prev_x    <= cur_x;
            prev_y    <= cur_y;
            have_prev <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (root_rsp.done) begin
            fin_norm <= root_rsp.root;
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            norm           <= fin_norm;
            negative_total <= fin_neg;
            saturated      <= fin_sat;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_root_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    root_rsp.done |-> state == S_ROOT)
    else $error("root done outside of root wait");

  a_root_start_nonneg: assert property (@(posedge clk) disable iff (rst)
    root_req.start |-> !acc[ACC_W-1] && cur_last)
    else $error("root started on negative or non-final total");

  a_cleared_in_root: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT |-> !have_prev && acc == '0 && !sat_seen)
    else $error("curve state not cleared after final point");

  a_neg_zero_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && negative_total |-> norm == '0)
    else $error("negative total with nonzero norm");

endmodule

>>> bench/piecewise_linear_l2_norm_core_test.sv
// Self-checking testbench for the piecewise linear L2 norm core: directed and random curves.
`timescale 1ns / 1ps

module piecewise_linear_l2_norm_core_test;
  import plnorm_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic [7:0]  pause;
    logic        drain;
  } point_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm;
    logic              negative;
    logic              clipped;
  } norm_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [15:0]       x_coord = '0;
  logic [15:0]       y_value = '0;
  logic              is_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NORM_W-1:0] norm;
  logic              negative_total;
  logic              saturated;

  point_t       curve_points[$];
  norm_result_t norm_queue[$];

  logic signed [15:0]      seg_x = '0;
  logic signed [15:0]      seg_y = '0;
  logic                    seg_open = 1'b0;
  logic signed [ACC_W-1:0] area3 = '0;
  logic                    area_clipped = 1'b0;

  logic        in_taken = 1'b0;
  int unsigned points_taken = 0;
  int unsigned waited = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;

  piecewise_linear_l2_norm_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .x_coord        (x_coord),
    .y_value        (y_value),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .norm           (norm),
    .negative_total (negative_total),
    .saturated      (saturated)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch on %s at %0t: got %0d, want %0d", what, $time, got, want);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic logic [NORM_W-1:0] floor_root(input logic [ACC_W-1:0] v);
    logic [NORM_W-1:0] r;
    logic [NORM_W-1:0] c;
    r = '0;
    for (int i = NORM_W - 1; i >= 0; i--) begin
      c = r | (NORM_W'(1) << i);
      if (ACC_W'(c) * ACC_W'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic void integrate_point(input logic signed [15:0] x,
                                          input logic signed [15:0] y, input logic last);
    logic signed [16:0]    dx;
    logic signed [33:0]    ysum;
    logic signed [50:0]    term;
    logic signed [ACC_W:0] total;
    norm_result_t          r;
    if (seg_open) begin
      dx = x - seg_x;
      ysum = seg_y * seg_y + seg_y * y + y * y;
      term = dx * ysum;
      total = area3 + term;
      if (total[ACC_W] != total[ACC_W-1]) begin
        area3 = total[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        area_clipped = 1'b1;
      end else begin
        area3 = total[ACC_W-1:0];
      end
    end
    seg_x = x;
    seg_y = y;
    seg_open = 1'b1;
    if (last) begin
      r.negative = area3[ACC_W-1];
      r.norm = r.negative ? '0 : floor_root($unsigned(area3) / 64'd3);
      r.clipped = area_clipped;
      norm_queue.push_back(r);
      seg_x = '0;
      seg_y = '0;
      seg_open = 1'b0;
      area3 = '0;
      area_clipped = 1'b0;
    end
  endfunction

  function automatic void queue_point(input int x, input int y, input bit last,
                                      input bit calm, input bit drain);
    point_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.last = last;
    p.pause = calm ? 8'd0 : 8'(pick_gap());
    p.drain = drain;
    curve_points.push_back(p);
  endfunction

  always @(posedge clk) begin : take_points
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        integrate_point(x_coord, y_value, is_last);
        points_taken++;
      end
    end
  end

  always @(posedge clk) begin : check_results
    norm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (norm_queue.size() == 0) begin
        report_mismatch("unexpected result norm", norm, 0);
      end else begin
        want = norm_queue.pop_front();
        if (norm !== want.norm) report_mismatch("norm", norm, want.norm);
        if (negative_total !== want.negative)
          report_mismatch("negative_total", negative_total, want.negative);
        if (saturated !== want.clipped) report_mismatch("saturated", saturated, want.clipped);
      end
    end
  end

  always @(negedge clk) begin : drive_points
    logic   next_valid;
    point_t p;
    next_valid = in_valid;
    if (!rst) begin
      if (in_valid && in_taken) next_valid = 1'b0;
      if (!next_valid && curve_points.size() != 0) begin
        if (waited < curve_points[0].pause) begin
          waited++;
        end else if (!(curve_points[0].drain && norm_queue.size() != 0)) begin
          p = curve_points.pop_front();
          x_coord <= p.x;
          y_value <= p.y;
          is_last <= p.last;
          next_valid = 1'b1;
          waited = 0;
        end
      end
    end
    in_valid <= next_valid;
  end

  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (((points_taken / 300) % 4) != 3 && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int n;
    int style;
    int x;
    int y;
    int sent;
    bit calm;

    queue_point(4660, -32768, 1, 0, 0);
    queue_point(-32768, -32768, 1, 0, 0);
    queue_point(-32768, -32768, 0, 0, 0);
    queue_point(32767, -32768, 1, 0, 0);
    queue_point(32767, 32767, 0, 0, 1);
    queue_point(-32768, 32767, 1, 0, 0);
    queue_point(100, 500, 0, 0, 0);
    queue_point(100, -700, 0, 0, 0);
    queue_point(300, 200, 1, 0, 0);
    queue_point(5, 0, 0, 0, 0);
    queue_point(10, 0, 1, 0, 0);
    queue_point(0, 32767, 0, 0, 0);
    queue_point(256, -32768, 0, 0, 0);
    queue_point(128, 1, 0, 0, 0);
    queue_point(32767, -1, 1, 0, 0);
    queue_point(-1, 1, 0, 0, 0);
    queue_point(1, -1, 0, 0, 0);
    queue_point(-32767, 32766, 1, 0, 0);

    sent = 0;
    while (sent < 1400) begin
      n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                      : int'($urandom_range(1, 8));
      style = $urandom_range(0, 3);
      calm = ($urandom_range(0, 5) == 0);
      x = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < n; k++) begin
        case (style)
          0: x = x + int'($urandom_range(0, 3000));
          1: x = int'($urandom_range(0, 65535)) - 32768;
          2: x = pick_edge();
          default: x = x - int'($urandom_range(0, 3000));
        endcase
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        y = (style == 2) ? pick_edge() : int'($urandom_range(0, 65535)) - 32768;
        queue_point(x, y, k == n - 1, calm, sent % 200 == 0);
        sent++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (curve_points.size() != 0 || in_valid) @(posedge clk);
    while (norm_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> piecewise_linear_l2_norm_core.f
src/plnorm_pkg.sv
src/plnorm_root.sv
src/piecewise_linear_l2_norm_core.sv
bench/piecewise_linear_l2_norm_core_test.sv
